FILE: src/ffha_pkg.sv
package ffha_pkg;

   // Internal byte offset width: covers window size plus one block of slack
   localparam int AddrW = 18;
   // Widest slot index over the supported window range
   localparam int IdxMaxW = 15;

   typedef struct packed {
      logic        busy;
      logic [15:0] size;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [IdxMaxW-1:0]   wr_idx;
      entry_type            wr_data;
      logic [IdxMaxW-1:0]   rd_idx;
   } mem_req_type;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_RESIZE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

endpackage

FILE: src/first_fit_heap_allocator.sv
// First-fit heap allocator. Each request (allocate, free, resize) walks the
// block headers in address order through a single header memory with a
// registered read port, and a final walk reports the largest free payload.
// A request may also write one or two headers for a split, write a released
// header and merge each following free block into it. One request is in
// flight at a time; the next is taken while the previous result waits in
// the output register. Writing csr_wdata reformats the heap as one free
// block at the start of the next request.
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = 4096,
   parameter int HEADER_BYTES = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // block_address[11:0], request_size[27:12], zero pad
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // result_address[11:0], copy_bytes[24:12],
                                   // largest_free[37:25], zero pad
   output logic [1:0]  rsp_tuser   // ok[0], moved[1]
);
   import ffha_pkg::*;

   localparam int Slots = (HEAP_BYTES + 1) / 2;
   localparam logic [AddrW-1:0] HeapMax = AddrW'(HEAP_BYTES);

   logic [12:0]      heap_bytes_ff;
   logic [AddrW-1:0] win;
   mem_req_type      mem_req;
   entry_type        rd_data;
   logic             ok;
   logic             moved;
   logic [11:0]      res_addr;
   logic [12:0]      copy_bytes;
   logic [12:0]      largest;

   // Hold the window size register
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_bytes_ff <= 13'd4096;
      end else if (csr_we) begin
         heap_bytes_ff <= csr_wdata;
      end
   end

   assign win = (AddrW'(heap_bytes_ff) > HeapMax) ? HeapMax : AddrW'(heap_bytes_ff);

   ffha_mem #(.DEPTH(Slots)) u_mem (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (rd_data)
   );

   ffha_seq #(.HEADER_BYTES(HEADER_BYTES)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg_clear   (csr_we),
      .win         (win),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_kind    (req_tuser),
      .req_addr    (req_tdata[11:0]),
      .req_size    (req_tdata[27:12]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_ok      (ok),
      .rsp_addr    (res_addr),
      .rsp_moved   (moved),
      .rsp_copy    (copy_bytes),
      .rsp_largest (largest),
      .mem_req     (mem_req),
      .rd_data     (rd_data)
   );

   assign rsp_tdata = {2'b00, largest, copy_bytes, res_addr};
   assign rsp_tuser = {moved, ok};

endmodule

FILE: src/ffha_mem.sv
module ffha_mem #(
   parameter int DEPTH = 2048
) (
   input  logic                 clock,
   input  ffha_pkg::mem_req_type req,
   output ffha_pkg::entry_type   rd_data
);
   import ffha_pkg::*;

   localparam int IdxW = $clog2(DEPTH);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write one header, read one header through a registered read port
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_idx[IdxW-1:0]] <= req.wr_data;
      end
      rd_data_ff <= mem_ff[req.rd_idx[IdxW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ffha_seq.sv
module ffha_seq #(
   parameter int HEADER_BYTES = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cfg_clear,
   input  logic [ffha_pkg::AddrW-1:0] win,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [1:0]                 req_kind,
   input  logic [11:0]                req_addr,
   input  logic [15:0]                req_size,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic                       rsp_ok,
   output logic [11:0]                rsp_addr,
   output logic                       rsp_moved,
   output logic [12:0]                rsp_copy,
   output logic [12:0]                rsp_largest,
   output ffha_pkg::mem_req_type      mem_req,
   input  ffha_pkg::entry_type        rd_data
);
   import ffha_pkg::*;

   localparam logic [AddrW-1:0] Hdr    = AddrW'(HEADER_BYTES);
   localparam logic [AddrW-1:0] MinTail = AddrW'(HEADER_BYTES + 2);

   typedef enum logic [4:0] {
      IDLE, FMT, DISP, AL_RD, AL_CHK, FD_RD, FD_CHK, RZ_RD, RZ_CHK,
      SP, SP_W2, MG_W, MG_RD, MG_CHK, LG_RD, LG_CHK, DONE
   } state_type;

   state_type        state_ff;
   logic             ready_ff;
   kind_type         kind_ff;
   logic [11:0]      addr_ff;
   logic [15:0]      size_ff;
   logic [AddrW-1:0] want_ff;
   logic [AddrW-1:0] b_ff;
   logic [AddrW-1:0] tgt_ff;
   logic [15:0]      tsize_ff;
   logic [AddrW-1:0] acc_ff;
   logic [AddrW-1:0] sp_base_ff;
   logic [AddrW-1:0] sp_size_ff;
   logic [AddrW-1:0] res_ff;
   logic             move_ff;
   logic             moved_ff;
   logic [15:0]      best_ff;
   logic             rsp_valid_ff;
   logic             rsp_ok_ff;
   logic [11:0]      rsp_addr_ff;
   logic             rsp_moved_ff;
   logic [12:0]      rsp_copy_ff;
   logic [12:0]      rsp_largest_ff;

   logic [AddrW-1:0] s_ext;
   logic [AddrW-1:0] nxt;
   logic [AddrW-1:0] tail;
   logic [AddrW-1:0] grow;
   logic [AddrW-1:0] nxt_m;
   logic             split_ok;

   // Header arithmetic shared by the walks
   assign s_ext    = AddrW'(rd_data.size);
   assign nxt      = b_ff + Hdr + s_ext;
   assign tail     = sp_size_ff - want_ff;
   assign split_ok = tail >= MinTail;
   assign grow     = AddrW'(tsize_ff) + Hdr + s_ext;
   assign nxt_m    = tgt_ff + Hdr + acc_ff;

   // Drive the header memory port
   always_comb begin
      mem_req         = '0;
      mem_req.rd_idx  = b_ff[IdxMaxW:1];
      unique case (state_ff)
         FMT: begin
            if (!ready_ff && win > Hdr) begin
               mem_req.wr_en        = 1'b1;
               mem_req.wr_idx       = '0;
               mem_req.wr_data.size = 16'(win - Hdr);
            end
         end
         SP: begin
            mem_req.wr_en = 1'b1;
            if (split_ok) begin
               mem_req.wr_idx       = IdxMaxW'((sp_base_ff + Hdr + want_ff) >> 1);
               mem_req.wr_data.size = 16'(tail - Hdr);
            end else begin
               mem_req.wr_idx       = sp_base_ff[IdxMaxW:1];
               mem_req.wr_data.busy = 1'b1;
               mem_req.wr_data.size = 16'(sp_size_ff);
            end
         end
         SP_W2: begin
            mem_req.wr_en        = 1'b1;
            mem_req.wr_idx       = sp_base_ff[IdxMaxW:1];
            mem_req.wr_data.busy = 1'b1;
            mem_req.wr_data.size = 16'(want_ff);
         end
         MG_W: begin
            mem_req.wr_en        = 1'b1;
            mem_req.wr_idx       = tgt_ff[IdxMaxW:1];
            mem_req.wr_data.size = 16'(acc_ff);
         end
         default: ;
      endcase
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once transferred, unless a new one replaces it
         if (rsp_valid_ff && rsp_tready && state_ff != DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_tvalid) begin
                  kind_ff  <= kind_type'(req_kind);
                  addr_ff  <= req_addr;
                  size_ff  <= req_size;
                  want_ff  <= (AddrW'(req_size) + AddrW'(1)) & ~AddrW'(1);
                  res_ff   <= '0;
                  move_ff  <= 1'b0;
                  moved_ff <= 1'b0;
                  tsize_ff <= '0;
                  best_ff  <= '0;
                  b_ff     <= '0;
                  state_ff <= FMT;
               end
            end
            FMT: begin
               if (!ready_ff && win > Hdr && !cfg_clear) begin
                  ready_ff <= 1'b1;
               end
               state_ff <= DISP;
            end
            DISP: begin
               if (!ready_ff) begin
                  state_ff <= DONE;
               end else begin
                  case (kind_ff)
                     KIND_ALLOC:  state_ff <= (size_ff == '0) ? LG_RD : AL_RD;
                     KIND_FREE:   state_ff <= (AddrW'(addr_ff) < Hdr) ? LG_RD : FD_RD;
                     KIND_RESIZE: begin
                        if (addr_ff == '0) begin
                           state_ff <= (size_ff == '0) ? LG_RD : AL_RD;
                        end else begin
                           state_ff <= (AddrW'(addr_ff) < Hdr) ? LG_RD : FD_RD;
                        end
                     end
                     default: state_ff <= LG_RD;
                  endcase
               end
            end
            AL_RD: state_ff <= AL_CHK;
            AL_CHK: begin
               if (!rd_data.busy && s_ext >= want_ff) begin
                  sp_base_ff <= b_ff;
                  sp_size_ff <= s_ext;
                  res_ff     <= b_ff + Hdr;
                  state_ff   <= SP;
               end else if (nxt < win) begin
                  b_ff     <= nxt;
                  state_ff <= AL_RD;
               end else begin
                  b_ff     <= '0;
                  state_ff <= LG_RD;
               end
            end
            FD_RD: state_ff <= FD_CHK;
            FD_CHK: begin
               if (b_ff + Hdr == AddrW'(addr_ff)) begin
                  tgt_ff   <= b_ff;
                  tsize_ff <= rd_data.size;
                  acc_ff   <= s_ext;
                  if (kind_ff == KIND_FREE) begin
                     state_ff <= MG_W;
                  end else if (!rd_data.busy) begin
                     b_ff     <= '0;
                     state_ff <= LG_RD;
                  end else if (size_ff == '0) begin
                     state_ff <= MG_W;
                  end else if (s_ext >= want_ff) begin
                     sp_base_ff <= b_ff;
                     sp_size_ff <= s_ext;
                     res_ff     <= AddrW'(addr_ff);
                     state_ff   <= SP;
                  end else if (nxt < win) begin
                     b_ff     <= nxt;
                     state_ff <= RZ_RD;
                  end else begin
                     move_ff  <= 1'b1;
                     b_ff     <= '0;
                     state_ff <= AL_RD;
                  end
               end else if (nxt < win) begin
                  b_ff     <= nxt;
                  state_ff <= FD_RD;
               end else begin
                  b_ff     <= '0;
                  state_ff <= LG_RD;
               end
            end
            RZ_RD: state_ff <= RZ_CHK;
            RZ_CHK: begin
               if (!rd_data.busy && grow >= want_ff) begin
                  sp_base_ff <= tgt_ff;
                  sp_size_ff <= grow;
                  res_ff     <= AddrW'(addr_ff);
                  state_ff   <= SP;
               end else begin
                  move_ff  <= 1'b1;
                  b_ff     <= '0;
                  state_ff <= AL_RD;
               end
            end
            SP, SP_W2: begin
               if (state_ff == SP && split_ok) begin
                  state_ff <= SP_W2;
               end else if (move_ff) begin
                  acc_ff   <= AddrW'(tsize_ff);
                  moved_ff <= 1'b1;
                  state_ff <= MG_W;
               end else begin
                  b_ff     <= '0;
                  state_ff <= LG_RD;
               end
            end
            MG_W: begin
               if (nxt_m < win) begin
                  b_ff     <= nxt_m;
                  state_ff <= MG_RD;
               end else begin
                  b_ff     <= '0;
                  state_ff <= LG_RD;
               end
            end
            MG_RD: state_ff <= MG_CHK;
            MG_CHK: begin
               if (!rd_data.busy) begin
                  acc_ff   <= acc_ff + Hdr + s_ext;
                  state_ff <= MG_W;
               end else begin
                  b_ff     <= '0;
                  state_ff <= LG_RD;
               end
            end
            LG_RD: state_ff <= LG_CHK;
            LG_CHK: begin
               if (!rd_data.busy && rd_data.size > best_ff) begin
                  best_ff <= rd_data.size;
               end
               if (nxt < win) begin
                  b_ff     <= nxt;
                  state_ff <= LG_RD;
               end else begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_ok_ff      <= res_ff != '0;
                  rsp_addr_ff    <= res_ff[11:0];
                  rsp_moved_ff   <= moved_ff;
                  rsp_copy_ff    <= moved_ff ? tsize_ff[12:0] : 13'd0;
                  rsp_largest_ff <= best_ff[12:0];
                  state_ff       <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
         // A new window size forces a fresh format
         if (cfg_clear) begin
            ready_ff <= 1'b0;
         end
      end
   end

   assign req_tready  = state_ff == IDLE;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_addr    = rsp_addr_ff;
   assign rsp_moved   = rsp_moved_ff;
   assign rsp_copy    = rsp_copy_ff;
   assign rsp_largest = rsp_largest_ff;

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == IDLE |-> !mem_req.wr_en)
      else $error("header write while idle");

   a_clear_ready: assert property (@(posedge clock) disable iff (reset)
      cfg_clear |=> !ready_ff)
      else $error("heap still marked formatted after window change");

   a_moved_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_moved_ff |-> rsp_ok_ff)
      else $error("move reported without a granted block");

endmodule

FILE: verif/first_fit_heap_allocator_tb.sv
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
   import ffha_pkg::*;

   localparam int HEAP_MAX   = 4096;
   localparam int HDR        = 6;
   localparam int SLOT_COUNT = HEAP_MAX / 2;
   localparam int NONE_BLK   = -1;
   localparam longint CYCLE_LIMIT = 60_000_000;

   typedef struct {
      bit        ok;
      bit [11:0] addr;
      bit        moved;
      bit [12:0] copy;
      bit [12:0] largest;
   } grant_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [12:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // block_address[11:0], request_size[27:12], zero pad
   logic [1:0]  req_tuser;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // result_address[11:0], copy_bytes[24:12], largest_free[37:25]
   logic [1:0]  rsp_tuser;   // ok[0], moved[1]

   // Heap shadow state
   int unsigned window_cfg;
   bit [15:0]   blk_size[SLOT_COUNT];
   bit          blk_busy[SLOT_COUNT];
   bit          heap_formatted;

   grant_type   pending_grants[$];
   int          mismatch_count;
   int          grant_count;
   int          ok_count;
   int          move_count;
   longint      cycle_count;
   bit          quiet_mode;
   int          hold_request;
   int          hold_left;

   first_fit_heap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------- heap shadow ----------------
   function automatic int win_bytes();
      return window_cfg > HEAP_MAX ? HEAP_MAX : window_cfg;
   endfunction

   function automatic int slot_of(int start);
      return (start >> 1) < SLOT_COUNT ? (start >> 1) : 0;
   endfunction

   function automatic int size_at(int start);
      return blk_size[slot_of(start)];
   endfunction

   function automatic bit busy_at(int start);
      return blk_busy[slot_of(start)];
   endfunction

   function automatic void put_block(int start, int size, bit busy);
      blk_size[slot_of(start)] = size[15:0];
      blk_busy[slot_of(start)] = busy;
   endfunction

   function automatic int next_blk(int start);
      int n;
      n = start + HDR + size_at(start);
      return n < win_bytes() ? n : NONE_BLK;
   endfunction

   function automatic int locate(int addr);
      if (!heap_formatted || addr < HDR) return NONE_BLK;
      for (int b = 0; b != NONE_BLK; b = next_blk(b))
         if (b + HDR == addr) return b;
      return NONE_BLK;
   endfunction

   function automatic void split_at(int b, int want);
      int tail;
      tail = size_at(b) - want;
      if (tail < HDR + 2) return;
      put_block(b + HDR + want, tail - HDR, 1'b0);
      put_block(b, want, busy_at(b));
   endfunction

   function automatic void release_blk(int b);
      int n;
      put_block(b, size_at(b), 1'b0);
      n = next_blk(b);
      while (n != NONE_BLK && !busy_at(n)) begin
         put_block(b, size_at(b) + HDR + size_at(n), busy_at(b));
         n = next_blk(b);
      end
   endfunction

   function automatic int first_fit(int size);
      int want;
      want = (size + 1) & ~1;
      if (size == 0 || !heap_formatted) return 0;
      for (int b = 0; b != NONE_BLK; b = next_blk(b)) begin
         if (busy_at(b) || size_at(b) < want) continue;
         split_at(b, want);
         put_block(b, size_at(b), 1'b1);
         return b + HDR;
      end
      return 0;
   endfunction

   function automatic int largest_hole();
      int best;
      best = 0;
      if (!heap_formatted) return 0;
      for (int b = 0; b != NONE_BLK; b = next_blk(b))
         if (!busy_at(b) && size_at(b) > best) best = size_at(b);
      return best;
   endfunction

   // Apply one request to the shadow heap and return the grant it produces
   function automatic grant_type apply_request(kind_type kind, int addr, int size);
      grant_type g;
      int res, copy, b, n, want, lg;
      bit moved;
      res = 0; copy = 0; moved = 0;
      if (!heap_formatted && win_bytes() > HDR) begin
         put_block(0, win_bytes() - HDR, 1'b0);
         heap_formatted = 1;
      end
      case (kind)
         KIND_ALLOC: res = first_fit(size);
         KIND_FREE: begin
            b = locate(addr);
            if (b != NONE_BLK) release_blk(b);
         end
         KIND_RESIZE: begin
            if (addr == 0) res = first_fit(size);
            else begin
               b = locate(addr);
               if (b != NONE_BLK && busy_at(b)) begin
                  want = (size + 1) & ~1;
                  n = next_blk(b);
                  if (size == 0) release_blk(b);
                  else if (size_at(b) >= want) begin
                     split_at(b, want);
                     res = addr;
                  end else if (n != NONE_BLK && !busy_at(n) &&
                               size_at(b) + HDR + size_at(n) >= want) begin
                     put_block(b, size_at(b) + HDR + size_at(n), 1'b1);
                     split_at(b, want);
                     res = addr;
                  end else begin
                     res = first_fit(size);
                     if (res != 0) begin
                        moved = 1;
                        copy = size_at(b);
                        release_blk(b);
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      lg = largest_hole();
      g.ok = res != 0;
      g.addr = res[11:0];
      g.moved = moved;
      g.copy = copy[12:0];
      g.largest = lg[12:0];
      return g;
   endfunction

   // Pick the payload address of some block in the current heap, or the first block's while unformatted
   function automatic int some_block_addr();
      int starts[$];
      if (!heap_formatted) return HDR;
      for (int b = 0; b != NONE_BLK; b = next_blk(b)) starts.push_back(b);
      return starts[$urandom_range(starts.size() - 1)] + HDR;
   endfunction

   // ---------------- cycle limit ----------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------- receiver ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 17);
         end
      end
   end

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      grant_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_grants.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transfer: tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
         end else begin
            e = pending_grants.pop_front();
            grant_count++;
            if (rsp_tuser[0] !== e.ok || rsp_tdata[11:0] !== e.addr ||
                rsp_tuser[1] !== e.moved || rsp_tdata[24:12] !== e.copy ||
                rsp_tdata[37:25] !== e.largest || rsp_tdata[39:38] !== 2'b00) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch at grant %0d: exp ok=%0d addr=%0d moved=%0d ",
                            "copy=%0d lf=%0d, got ok=%0d addr=%0d moved=%0d ",
                            "copy=%0d lf=%0d"},
                           grant_count, e.ok, e.addr, e.moved, e.copy, e.largest,
                           rsp_tuser[0], rsp_tdata[11:0], rsp_tuser[1],
                           rsp_tdata[24:12], rsp_tdata[37:25]);
            end
            if (e.ok) ok_count++;
            if (e.moved) move_count++;
         end
      end
   end

   // ---------------- sender ----------------
   task automatic send_request(kind_type kind, int addr, int size);
      grant_type g;
      if (!quiet_mode && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, size[15:0], addr[11:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      g = apply_request(kind, addr, size);
      pending_grants.push_back(g);
   endtask

   task automatic drop_valid();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until the block has returned every grant
   task automatic drain();
      drop_valid();
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_window(int bytes);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= bytes[12:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      window_cfg = bytes & 16'h1FFF;
      heap_formatted = 0;
      @(posedge clock);
   endtask

   task automatic random_request();
      int pick, addr, size;
      kind_type kind;
      pick = $urandom_range(99);
      kind = pick < 42 ? KIND_ALLOC : pick < 70 ? KIND_FREE : pick < 96 ? KIND_RESIZE
                                                                         : KIND_NONE;
      pick = $urandom_range(99);
      addr = pick < 80 ? some_block_addr() : pick < 88 ? 0 : $urandom_range(4095);
      pick = $urandom_range(99);
      size = pick < 70 ? $urandom_range(1, 120) : pick < 88 ? $urandom_range(1, 4096)
           : pick < 94 ? 0 : $urandom_range(65535);
      send_request(kind, addr, size);
   endtask

   // ---------------- tests ----------------
   task automatic test_directed_cases();
      int a, b, c;
      send_request(KIND_ALLOC, 0, 0);
      send_request(KIND_ALLOC, 0, 65535);
      send_request(KIND_ALLOC, 0, 4091);
      send_request(KIND_ALLOC, 0, 4090);
      send_request(KIND_FREE, HDR, 0);
      send_request(KIND_ALLOC, 0, 1);
      send_request(KIND_ALLOC, 0, 21);
      send_request(KIND_ALLOC, 0, 30);
      a = HDR; b = HDR + 2 + HDR; c = b + 22 + HDR;
      send_request(KIND_FREE, b, 0);
      send_request(KIND_FREE, b, 0);
      send_request(KIND_FREE, 7, 0);
      send_request(KIND_FREE, 0, 0);
      send_request(KIND_RESIZE, 0, 8);
      send_request(KIND_RESIZE, c, 4);
      send_request(KIND_RESIZE, a, 20);
      send_request(KIND_RESIZE, a, 600);
      send_request(KIND_RESIZE, b, 10);
      send_request(KIND_RESIZE, c, 65535);
      send_request(KIND_RESIZE, c, 0);
      send_request(KIND_RESIZE, 4095, 2);
      send_request(KIND_NONE, 4095, 65535);
      send_request(KIND_ALLOC, 4095, 3000);
      drain();
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) random_request();
   endtask

   task automatic test_output_backpressure();
      drain();
      hold_request = 400;
      repeat (30) random_request();
      drain();
   endtask

   task automatic test_window_sweep();
      int sizes[8] = '{0, 6, 7, 8, 14, 64, 200, 8191};
      foreach (sizes[i]) begin
         set_window(sizes[i]);
         repeat (90) random_request();
      end
      set_window(HEAP_MAX);
   endtask

   task automatic test_steady_stream(int count);
      drain();
      quiet_mode = 1;
      repeat (count) random_request();
      drain();
      quiet_mode = 0;
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_ALLOC;
      mismatch_count = 0;
      grant_count = 0;
      ok_count = 0;
      move_count = 0;
      cycle_count = 0;
      quiet_mode = 0;
      hold_request = 0;
      hold_left = 0;
      window_cfg = HEAP_MAX;
      heap_formatted = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_traffic(700);
      test_output_backpressure();
      test_window_sweep();
      test_steady_stream(300);
      test_random_traffic(160);
      drain();
      repeat (200) @(posedge clock);

      $display("covered %0d grants (%0d granted, %0d relocations) over %0d cycles",
               grant_count, ok_count, move_count, cycle_count);
      $display("windows swept from empty to saturated, with output stalls and steady runs");
      if (mismatch_count == 0 && pending_grants.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: files.f
src/ffha_pkg.sv
src/ffha_mem.sv
src/ffha_seq.sv
src/first_fit_heap_allocator.sv
verif/first_fit_heap_allocator_tb.sv
